// File: rtl/urtp_pkg.sv
// Shared types and constants of the user record text parser.
`timescale 1ns / 1ps
`default_nettype none

package urtp_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_HASH_LEN  = 3'd1,
		ST_NAME_LONG = 3'd2,
		ST_BAD_ROLE  = 3'd3,
		ST_ENDED     = 3'd4
	} status_t;

	// Configuration register indexes
	localparam logic [1:0] REG_ROLE_NONE  = 2'd0;
	localparam logic [1:0] REG_ROLE_USER  = 2'd1;
	localparam logic [1:0] REG_ROLE_QUERY = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// Role masks as seen by the parser
	typedef struct packed {
		logic [7:0] none_mask;
		logic [7:0] user_mask;
		logic [7:0] query_mask;
	} cfg_t;

	// One finished record
	typedef struct packed {
		status_t     status;
		logic [63:0] user_id;
		logic [4:0]  name_length;
		logic [63:0] name_word0;
		logic [63:0] name_word1;
		logic [63:0] name_word2;
		logic [63:0] name_word3;
		logic [63:0] password_hash;
		logic [7:0]  roles;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/urtp_char_if.sv
// Character channel: valid, ready and one text character.
`timescale 1ns / 1ps
`default_nettype none

interface urtp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       input_ended;

	modport source (output valid, output char_in, output input_ended, input ready);
	modport sink   (input valid, input char_in, input input_ended, output ready);
endinterface

`default_nettype wire

// File: rtl/urtp_rec_if.sv
// Record channel: valid, ready and one parsed user record.
`timescale 1ns / 1ps
`default_nettype none

interface urtp_rec_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] user_id;
	logic [4:0]  name_length;
	logic [63:0] name_word0;
	logic [63:0] name_word1;
	logic [63:0] name_word2;
	logic [63:0] name_word3;
	logic [63:0] password_hash;
	logic [7:0]  roles;

	modport source (
		output valid, output status, output user_id, output name_length,
		output name_word0, output name_word1, output name_word2, output name_word3,
		output password_hash, output roles, input ready
	);
	modport sink (
		input valid, input status, input user_id, input name_length,
		input name_word0, input name_word1, input name_word2, input name_word3,
		input password_hash, input roles, output ready
	);
endinterface

`default_nettype wire

// File: rtl/user_record_text_parser.sv
// Top level: user record text parser.
// Takes one character per cycle unless the result register is full and not being read;
// the character that finishes a record passes through the input register, then the
// parsing step on the record state, into the result register.
// Reset clears the record state to the id phase and sets the role masks to 0, 1, 2.
`timescale 1ns / 1ps
`default_nettype none

module user_record_text_parser #(
	parameter int NAME_CAPACITY = 32,
	parameter int HASH_DIGITS   = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	urtp_char_if.sink                             text,
	urtp_rec_if.source                            record,
	input  wire logic                             cfg_wr_en,
	input  wire logic [urtp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [urtp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import urtp_pkg::*;

	cfg_t    cfg;
	result_t res;
	logic    res_load;
	logic    out_free;

	urtp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	urtp_parse_core #(
		.NAME_CAPACITY (NAME_CAPACITY),
		.HASH_DIGITS   (HASH_DIGITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.cfg      (cfg),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res)
	);

	urtp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_load),
		.res      (res),
		.out_free (out_free),
		.record   (record)
	);

endmodule

`default_nettype wire

// File: rtl/urtp_cfg_regs.sv
// Role mask registers behind the plain write port.
`timescale 1ns / 1ps
`default_nettype none

module urtp_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [urtp_pkg::CFG_INDEX_W-1:0] index,
	input  wire logic [urtp_pkg::CFG_DATA_W-1:0]  data,
	output urtp_pkg::cfg_t                       cfg
);
	import urtp_pkg::*;

	cfg_t cfg_q;

	// Take a write into the addressed mask; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.none_mask  <= 8'h00;
			cfg_q.user_mask  <= 8'h01;
			cfg_q.query_mask <= 8'h02;
		end else if (wr_en) begin
			case (index)
				REG_ROLE_NONE:  cfg_q.none_mask  <= data[7:0];
				REG_ROLE_USER:  cfg_q.user_mask  <= data[7:0];
				REG_ROLE_QUERY: cfg_q.query_mask <= data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/urtp_parse_core.sv
// Input register and record parsing step with the record state.
`timescale 1ns / 1ps
`default_nettype none

module urtp_parse_core #(
	parameter int NAME_CAPACITY = 32,
	parameter int HASH_DIGITS   = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	urtp_char_if.sink       text,
	input  wire urtp_pkg::cfg_t cfg,
	input  wire logic       out_free,
	output logic            res_load,
	output urtp_pkg::result_t res
);
	import urtp_pkg::*;

	// Only the first 32 name bytes are ever visible
	localparam int NAME_DEPTH = (NAME_CAPACITY < 32) ? NAME_CAPACITY : 32;
	localparam int NAME_IDX_W = $clog2(NAME_DEPTH);

	typedef enum logic [1:0] {PH_ID, PH_NAME, PH_HASH, PH_ROLE} phase_t;

	// Character classes
	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
	endfunction

	function automatic logic is_lower_hex(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h66);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d) || (c == 8'h20);
	endfunction

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       ended_s1;

	// Record state
	phase_t      phase_q, phase_d;
	logic [5:0]  cnt_q, cnt_d;
	logic [63:0] id_q, id_d;
	logic [63:0] hash_q, hash_d;
	logic [7:0]  roles_q, roles_d;
	logic [5:0]  name_len_q, name_len_d;
	logic [7:0]  name_q [NAME_DEPTH];
	logic        name_we;
	logic        emit;
	status_t     emit_status;

	logic        step_en;
	logic [5:0]  cnt_inc;
	logic [67:0] id_sum;
	logic [3:0]  digit;
	logic [255:0] name_flat;

	assign step_en    = valid_s1 && out_free;
	assign text.ready = !valid_s1 || out_free;

	// Hold a character until the step can consume it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			char_s1  <= text.char_in;
			ended_s1 <= text.input_ended;
		end
	end

	assign cnt_inc = (cnt_q == 6'h3f) ? cnt_q : cnt_q + 6'd1;
	assign digit   = is_digit(char_s1) ? 4'(char_s1 - 8'h30) : 4'(char_s1 - 8'h57);
	// id * 10 + digit with headroom to spot overflow
	assign id_sum  = ({4'b0, id_q} << 3) + ({4'b0, id_q} << 1) + 68'(digit);

	// Work out the next record state and any result
	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		id_d        = id_q;
		hash_d      = hash_q;
		roles_d     = roles_q;
		name_len_d  = name_len_q;
		name_we     = 1'b0;
		emit        = 1'b0;
		emit_status = ST_OK;
		if (ended_s1) begin
			emit        = 1'b1;
			emit_status = ST_ENDED;
		end else begin
			case (phase_q)
				PH_ID: begin
					if (is_blank(char_s1)) begin
						if (cnt_q != 6'd0) begin
							phase_d = PH_NAME;
							cnt_d   = 6'd0;
						end
					end else if (is_digit(char_s1)) begin
						id_d  = (id_sum[67:64] != 4'd0) ? {64{1'b1}} : id_sum[63:0];
						cnt_d = cnt_inc;
					end
				end
				PH_NAME: begin
					if (is_blank(char_s1)) begin
						if (cnt_q != 6'd0) begin
							name_len_d = cnt_q;
							phase_d    = PH_HASH;
							cnt_d      = 6'd0;
						end
					end else if (is_digit(char_s1) || is_letter(char_s1)) begin
						name_we = ({1'b0, cnt_q} < 7'(NAME_DEPTH));
						cnt_d   = cnt_inc;
						if ({1'b0, cnt_inc} >= 7'(NAME_CAPACITY)) begin
							emit        = 1'b1;
							emit_status = ST_NAME_LONG;
						end
					end
				end
				PH_HASH: begin
					if (is_blank(char_s1)) begin
						if (cnt_q != 6'd0) begin
							if (cnt_q != 6'(HASH_DIGITS)) begin
								emit        = 1'b1;
								emit_status = ST_HASH_LEN;
							end else begin
								phase_d = PH_ROLE;
								cnt_d   = 6'd0;
							end
						end
					end else if (is_digit(char_s1) || is_lower_hex(char_s1)) begin
						hash_d = {hash_q[59:0], digit};
						cnt_d  = cnt_inc;
					end
				end
				PH_ROLE: begin
					if (is_blank(char_s1)) begin
						if (cnt_q != 6'd0) begin
							emit        = 1'b1;
							emit_status = ST_OK;
						end
					end else if (char_s1 == 8'h2d) begin
						roles_d = roles_q | cfg.none_mask;
						cnt_d   = cnt_inc;
					end else if (char_s1 == 8'h75) begin
						roles_d = roles_q | cfg.user_mask;
						cnt_d   = cnt_inc;
					end else if (char_s1 == 8'h71) begin
						roles_d = roles_q | cfg.query_mask;
						cnt_d   = cnt_inc;
					end else if (is_letter(char_s1)) begin
						emit        = 1'b1;
						emit_status = ST_BAD_ROLE;
					end
				end
				default: ;
			endcase
		end
		// Restart at the id phase after any result
		if (emit) begin
			phase_d = PH_ID;
			cnt_d   = 6'd0;
			id_d    = 64'd0;
			hash_d  = 64'd0;
			roles_d = 8'd0;
		end
	end

	// Advance the record state on each consumed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ID;
			cnt_q      <= 6'd0;
			id_q       <= 64'd0;
			hash_q     <= 64'd0;
			roles_q    <= 8'd0;
			name_len_q <= 6'd0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			id_q       <= id_d;
			hash_q     <= hash_d;
			roles_q    <= roles_d;
			name_len_q <= name_len_d;
		end
	end

	// Store name bytes; bytes past the name length are masked on the way out
	always_ff @(posedge clk) begin
		if (step_en && name_we) begin
			name_q[cnt_q[NAME_IDX_W-1:0]] <= char_s1;
		end
	end

	for (genvar i = 0; i < 32; i++) begin : g_name
		if (i < NAME_DEPTH) begin : g_used
			assign name_flat[8*i +: 8] = (6'(i) < name_len_q) ? name_q[i] : 8'h00;
		end else begin : g_unused
			assign name_flat[8*i +: 8] = 8'h00;
		end
	end

	// Build the result; fields other than status are zero unless the record is good
	assign res_load = step_en && emit;

	always_comb begin
		res        = '0;
		res.status = emit_status;
		if (emit_status == ST_OK) begin
			res.user_id       = id_q;
			res.name_length   = (name_len_q > 6'd31) ? 5'd31 : name_len_q[4:0];
			res.name_word0    = name_flat[63:0];
			res.name_word1    = name_flat[127:64];
			res.name_word2    = name_flat[191:128];
			res.name_word3    = name_flat[255:192];
			res.password_hash = hash_q;
			res.roles         = roles_q;
		end
	end

endmodule

`default_nettype wire

// File: rtl/urtp_out_reg.sv
// Result register that holds a record until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module urtp_out_reg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         load,
	input  wire urtp_pkg::result_t res,
	output logic              out_free,
	urtp_rec_if.source        record
);
	import urtp_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign out_free = !valid_q || record.ready;

	// Hold the item until taken; refill in the same cycle it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res;
		end
	end

	assign record.valid         = valid_q;
	assign record.status        = res_q.status;
	assign record.user_id       = res_q.user_id;
	assign record.name_length   = res_q.name_length;
	assign record.name_word0    = res_q.name_word0;
	assign record.name_word1    = res_q.name_word1;
	assign record.name_word2    = res_q.name_word2;
	assign record.name_word3    = res_q.name_word3;
	assign record.password_hash = res_q.password_hash;
	assign record.roles         = res_q.roles;

endmodule

`default_nettype wire
